@@ design/qarc_pkg.sv @@
// ----------------------------------------------------------------------------
// qarc_pkg: shared types and constants for the attitude rate controller
// Holds the default widths, register indexes, PWM band pulse counts, the multiply request type and a saturation helper.
// ----------------------------------------------------------------------------
package qarc_pkg;

  localparam int CounterBitsDef  = 11;
  localparam int FractionBitsDef = 24;

  // Configuration register indexes.
  localparam logic [2:0] REG_RATE_PER_COUNT = 3'd0;
  localparam logic [2:0] REG_TICK_PERIOD    = 3'd1;
  localparam logic [2:0] REG_ANGLE_GAIN     = 3'd2;
  localparam logic [2:0] REG_RATE_GAIN      = 3'd3;
  localparam logic [2:0] REG_RATE_THRESHOLD = 3'd4;
  localparam logic [2:0] REG_ANGLE_LIMIT    = 3'd5;
  localparam logic [2:0] REG_PWM_STEP       = 3'd6;

  // PWM pulse counts per band.
  localparam logic [7:0] PULSE_L1 = 8'h28;
  localparam logic [7:0] PULSE_L2 = 8'h50;
  localparam logic [7:0] PULSE_L3 = 8'h78;
  localparam logic [7:0] PULSE_L4 = 8'hA0;
  localparam logic [7:0] PULSE_L5 = 8'hC7;

  // Request to the shared multiply unit.
  typedef struct packed {
    logic               start;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic [5:0]         shift;
  } mul_req_t;

  // Saturate a wide value to signed 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    if (v > 72'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -72'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

@@ design/qarc_mul.sv @@
// ----------------------------------------------------------------------------
// qarc_mul: shared multiply unit
// Multiplies two signed operands through four 32x32 partial products, then
// rounds the product to nearest (ties up) by a given right shift.
// ----------------------------------------------------------------------------
module qarc_mul
  import qarc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  mul_req_t            req,
  output logic                done,
  output logic signed [71:0]  result
);

  logic [2:0]          step_r, step_nxt;
  logic                neg_r;
  logic [63:0]         ma_r, mb_r;
  logic [127:0]        acc_r;
  logic [5:0]          sh_r;
  logic                done_r;
  logic signed [71:0]  res_r;
  logic [63:0]         pp;
  logic [127:0]        pp_sh;
  logic signed [128:0] sgn;
  logic signed [128:0] rnd;

  // Magnitudes go through four unsigned partial products.
  always_comb begin
    unique case (step_r[1:0])
      2'd0: pp = 64'(ma_r[31:0]) * 64'(mb_r[31:0]);
      2'd1: pp = 64'(ma_r[63:32]) * 64'(mb_r[31:0]);
      2'd2: pp = 64'(ma_r[31:0]) * 64'(mb_r[63:32]);
      default: pp = 64'(ma_r[63:32]) * 64'(mb_r[63:32]);
    endcase
    unique case (step_r[1:0])
      2'd0: pp_sh = 128'(pp);
      2'd1, 2'd2: pp_sh = 128'(pp) << 32;
      default: pp_sh = 128'(pp) << 64;
    endcase
    sgn = neg_r ? -$signed({1'b0, acc_r}) : $signed({1'b0, acc_r});
    // A zero shift passes the exact product through unrounded.
    rnd = (sh_r == 6'd0) ? sgn : ((sgn + (129'sd1 <<< (sh_r - 6'd1))) >>> sh_r);
  end

  always_comb begin
    step_nxt = step_r;
    if (req.start) step_nxt = 3'd1;
    else if (step_r != 3'd0) step_nxt = (step_r == 3'd5) ? 3'd0 : step_r + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 3'd0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      done_r <= (step_r == 3'd5);
    end
    if (req.start) begin
      ma_r  <= req.a[63] ? 64'(-req.a) : req.a;
      mb_r  <= req.b[63] ? 64'(-req.b) : req.b;
      neg_r <= req.a[63] ^ req.b[63];
      sh_r  <= req.shift;
      acc_r <= '0;
    end else if (step_r >= 3'd1 && step_r <= 3'd4) begin
      acc_r <= acc_r + pp_sh;
    end
    if (step_r == 3'd5) res_r <= rnd[71:0];
  end

  // Steps 1 to 4 each add one partial product; step 5 rounds the sum.
  assign done   = done_r;
  assign result = res_r;

endmodule

@@ design/quaternion_attitude_rate_controller.sv @@
// ----------------------------------------------------------------------------
// quaternion_attitude_rate_controller: quaternion PD attitude controller
// One encoder tick in, one PWM/rate result out; products run on a shared
// multiply unit under a small sequencer.
// ----------------------------------------------------------------------------
//  channel  direction  contents
//  in_      slave      tdata = encoder_count
//  out_     master     tdata = pulse_count, drive_direction, rate_estimate
//  cfg_     write      register index and data, no read-back
//
// A tick runs eighteen products through the multiply unit between accepting
// the input and handing over the result. The sequencer holds in_tready low
// from acceptance until the result has been taken and the sequencer is back
// in idle. rst_n is synchronous; it restores the register defaults and the
// initial attitude.
// The result stays in an output register while out_tready is low.
module quaternion_attitude_rate_controller
  import qarc_pkg::*;
#(
  parameter int COUNTER_BITS  = CounterBitsDef,
  parameter int FRACTION_BITS = FractionBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [((COUNTER_BITS+7)/8)*8-1:0] in_tdata, // [COUNTER_BITS-1:0] encoder_count
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata, // [7:0] pulse_count, [8] drive_direction,
                                 // [40:9] rate_estimate
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic [5:0] FB = 6'(FRACTION_BITS);
  localparam logic signed [71:0] One = 72'sd1 <<< FRACTION_BITS;
  localparam logic signed [31:0] Half = 32'((((64'd7071) << FRACTION_BITS) + 64'd5000) / 64'd10000);
  localparam logic signed [COUNTER_BITS+1:0] Range = (COUNTER_BITS+2)'(1) <<< COUNTER_BITS;
  localparam logic signed [COUNTER_BITS+1:0] HalfR = Range >>> 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_OUT = 3'd3;

  // Configuration registers.
  logic [24:0] rpc_r, tp_r, step_r;
  logic [30:0] ag_r, rg_r;
  logic signed [31:0] thr_r;
  logic signed [25:0] alim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rpc_r  <= 25'd2550;
      tp_r   <= 25'd3355443;
      ag_r   <= 31'd33554432;
      rg_r   <= 31'd117440512;
      thr_r  <= -32'sd1677722;
      alim_r <= 26'sd5738168;
      step_r <= 25'd150995;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_RATE_PER_COUNT: rpc_r  <= cfg_data[24:0];
        REG_TICK_PERIOD:    tp_r   <= cfg_data[24:0];
        REG_ANGLE_GAIN:     ag_r   <= cfg_data[30:0];
        REG_RATE_GAIN:      rg_r   <= cfg_data[30:0];
        REG_RATE_THRESHOLD: thr_r  <= cfg_data;
        REG_ANGLE_LIMIT:    alim_r <= cfg_data[25:0];
        REG_PWM_STEP:       step_r <= cfg_data[24:0];
        default: ;
      endcase
    end
  end

  // State.
  logic [2:0]  st_r, st_nxt;
  logic [4:0]  op_r;
  logic [COUNTER_BITS-1:0] prev_r;
  logic signed [31:0] r0_r, r1_r, r2_r, r3_r, cmd_r, rate_r;
  logic signed [31:0] p1_r, p0_r, q0_r, q1_r, q2_r, q3_r, t_r;
  logic signed [71:0] acc_r;
  logic [7:0]  pulse_r;
  logic        dir_r;
  logic [47:0] odata_r;
  logic        ovalid_r;

  mul_req_t           req;
  logic               mdone;
  logic signed [71:0] mres;

  qarc_mul u_mul (.clk(clk), .rst_n(rst_n), .req(req), .done(mdone), .result(mres));

  // Wrapped count difference, held from the accepting edge for the first product.
  logic [COUNTER_BITS-1:0] cnt;
  logic signed [COUNTER_BITS+1:0] d0, diff;
  logic signed [COUNTER_BITS+1:0] diff_r;
  assign cnt = in_tdata[COUNTER_BITS-1:0];
  always_comb begin
    d0 = $signed({2'b00, cnt}) - $signed({2'b00, prev_r});
    if (d0 >= 0) diff = (d0 < HalfR) ? d0 : d0 - Range;
    else diff = (-d0 < HalfR) ? d0 : d0 + Range;
  end

  // PWM band from the stored command.
  logic [32:0] m, s;
  logic [7:0]  pulses;
  always_comb begin
    m = cmd_r[31] ? 33'(-{cmd_r[31], cmd_r}) : 33'(cmd_r);
    s = 33'(step_r);
    if (m < s) pulses = 8'd0;
    else if (35'(m) * 2 <= 35'(s) * 3) pulses = PULSE_L1;
    else if (m <= s * 2) pulses = PULSE_L2;
    else if (35'(m) * 2 <= 35'(s) * 5) pulses = PULSE_L3;
    else if (35'(m) <= 35'(s) * 3) pulses = PULSE_L4;
    else pulses = PULSE_L5;
  end

  // Operand selection for each product step.
  logic signed [63:0] oa, ob;
  logic [5:0] osh;
  always_comb begin
    oa = 64'(r0_r); ob = 64'(r0_r); osh = FB;
    case (op_r)
      5'd0:  begin oa = 64'(diff_r); ob = 64'($signed({1'b0, rpc_r})); osh = 6'd0; end
      5'd1:  begin oa = 64'(rate_r); ob = 64'($signed({1'b0, tp_r})); osh = FB + 6'd1; end
      5'd2:  begin oa = 64'(p1_r); ob = 64'(p1_r); end
      5'd3:  begin oa = 64'(r0_r); ob = 64'(r0_r); end
      5'd4:  begin oa = 64'(r1_r); ob = 64'(r1_r); end
      5'd5:  begin oa = 64'(r2_r); ob = 64'(r2_r); end
      5'd6:  begin oa = 64'(r3_r); ob = 64'(r3_r); end
      5'd7:  begin oa = 64'(r0_r); ob = 64'(p0_r); end
      5'd8:  begin oa = 64'(r1_r); ob = 64'(p1_r); end
      5'd9:  begin oa = 64'(r0_r); ob = 64'(p1_r); end
      5'd10: begin oa = 64'(r1_r); ob = 64'(p0_r); end
      5'd11: begin oa = 64'(r2_r); ob = 64'(p0_r); end
      5'd12: begin oa = 64'(r3_r); ob = 64'(p1_r); end
      5'd13: begin oa = 64'(r3_r); ob = 64'(p0_r); end
      5'd14: begin oa = 64'(r2_r); ob = 64'(p1_r); end
      5'd15: begin oa = 64'(q0_r); ob = 64'(q1_r); end
      5'd16: begin oa = 64'($signed({1'b0, ag_r})); ob = 64'(t_r); end
      5'd17: begin oa = 64'($signed({1'b0, rg_r})); ob = 64'(rate_r); end
      default: ;
    endcase
  end

  assign req.start = (st_r == S_ISSUE);
  assign req.a = oa;
  assign req.b = ob;
  assign req.shift = osh;

  logic signed [31:0] ms;
  assign ms = sat32(mres);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE:  if (in_tvalid) st_nxt = S_ISSUE;
      S_ISSUE: st_nxt = S_WAIT;
      S_WAIT:  if (mdone) st_nxt = (op_r == 5'd17) ? S_OUT : S_ISSUE;
      S_OUT:   if (!ovalid_r) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      op_r <= 5'd0;
      prev_r <= '0;
      r0_r <= Half; r1_r <= Half; r2_r <= '0; r3_r <= '0;
      cmd_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      if (st_r == S_IDLE && in_tvalid) begin
        pulse_r <= pulses;
        dir_r <= ~cmd_r[31] && (cmd_r != 0);
        prev_r <= cnt;
        diff_r <= diff;
        op_r <= 5'd0;
      end
      if (st_r == S_WAIT && mdone) begin
        op_r <= op_r + 5'd1;
        case (op_r)
          5'd0: rate_r <= ms;
          5'd1: p1_r <= ms;
          5'd2: acc_r <= 72'(ms);
          5'd3: t_r <= ms;
          5'd4: t_r <= sat32(72'(t_r) + 72'(ms));
          5'd5: t_r <= sat32(72'(t_r) + 72'(ms));
          5'd6: p0_r <= sat32(((3 * One - acc_r
                  - 72'(sat32(72'(t_r) + 72'(ms)))) + 72'sd1) >>> 1);
          5'd7: t_r <= ms;
          5'd8: q0_r <= sat32(72'(t_r) - 72'(ms));
          5'd9: t_r <= ms;
          5'd10: q1_r <= sat32(72'(t_r) + 72'(ms));
          5'd11: t_r <= ms;
          5'd12: q2_r <= sat32(72'(t_r) + 72'(ms));
          5'd13: t_r <= ms;
          5'd14: q3_r <= sat32(72'(t_r) - 72'(ms));
          5'd15: t_r <= ms;
          5'd16: t_r <= ms;
          5'd17: begin
            if (r1_r < 32'(alim_r))
              cmd_r <= sat32(-(72'(t_r) + 72'(ms)));
            else
              cmd_r <= (rate_r > thr_r) ? -32'(One) : 32'sd0;
            r0_r <= q0_r; r1_r <= q1_r; r2_r <= q2_r; r3_r <= q3_r;
            odata_r <= {7'd0, rate_r, dir_r, pulse_r};
            ovalid_r <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

  // The block is busy whenever a result is pending.
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input ready while result pending");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready) else $error("ready after accept");
  a_issue_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_ISSUE) |=> (st_r == S_WAIT)) else $error("sequencer skipped wait");

endmodule

@@ tb/quaternion_attitude_rate_controller_checker.sv @@
// ----------------------------------------------------------------------------
// Attitude rate controller checker
// Watches the configuration port and both stream channels, keeps its own
// fixed-point model of the controller and compares every result transfer
// field by field with the oldest predicted tick result.
// ----------------------------------------------------------------------------
module quaternion_attitude_rate_controller_checker
  import qarc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending_ticks,
  output int          ticks_checked
);

  localparam int CntBits  = 11;
  localparam int FracBits = 24;
  localparam longint One  = 64'sd1 << FracBits;

  typedef struct packed {
    logic [7:0]         pulses;
    logic               direction;
    logic signed [31:0] rate;
  } tick_result_t;

  tick_result_t expected_ticks[$];

  // Controller registers and state of the prediction.
  longint rate_per_count, tick_period, angle_gain, rate_gain;
  longint rate_threshold, angle_limit, pwm_step;
  longint last_count;
  longint quat[4];
  longint command;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Round to nearest, ties toward plus infinity (arithmetic shift is a floor).
  function automatic longint round_shift(longint v, int s);
    longint t;
    t = v + (64'sd1 <<< (s - 1));
    return t >>> s;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return clamp32(round_shift(a * b, FracBits));
  endfunction

  task automatic restore_defaults();
    rate_per_count = 2550;
    tick_period    = 3355443;
    angle_gain     = 33554432;
    rate_gain      = 117440512;
    rate_threshold = -1677722;
    angle_limit    = 5738168;
    pwm_step       = 150995;
    last_count     = 0;
    quat[0] = ((64'sd7071 << FracBits) + 5000) / 10000;
    quat[1] = quat[0];
    quat[2] = 0;
    quat[3] = 0;
    command = 0;
  endtask

  // Advance the controller by one tick and return what it reports.
  function automatic tick_result_t advance_tick(logic [10:0] count);
    tick_result_t res;
    longint m, s, cnt, diff, rate, p0, p1, sp, sr, q0, q1, q2, q3;
    longint half_range;
    half_range = 64'sd1 << (CntBits - 1);
    m = (command < 0) ? -command : command;
    s = pwm_step;
    if (m < s) res.pulses = 8'd0;
    else if (2 * m <= 3 * s) res.pulses = PULSE_L1;
    else if (m <= 2 * s) res.pulses = PULSE_L2;
    else if (2 * m <= 5 * s) res.pulses = PULSE_L3;
    else if (m <= 3 * s) res.pulses = PULSE_L4;
    else res.pulses = PULSE_L5;
    res.direction = (command > 0);

    cnt = count;
    if (cnt >= last_count)
      diff = (cnt - last_count < half_range) ? cnt - last_count
                                             : cnt - last_count - 2 * half_range;
    else
      diff = (last_count - cnt < half_range) ? cnt - last_count
                                             : 2 * half_range + cnt - last_count;
    last_count = cnt;
    rate = clamp32(diff * rate_per_count);
    res.rate = rate[31:0];

    p1 = clamp32(round_shift(rate * tick_period, FracBits + 1));
    sp = qmul(p1, p1);
    sr = clamp32(qmul(quat[0], quat[0]) + qmul(quat[1], quat[1]) +
                 qmul(quat[2], quat[2]) + qmul(quat[3], quat[3]));
    p0 = clamp32(round_shift(3 * One - sp - sr, 1));
    q0 = clamp32(qmul(quat[0], p0) - qmul(quat[1], p1));
    q1 = clamp32(qmul(quat[0], p1) + qmul(quat[1], p0));
    q2 = clamp32(qmul(quat[2], p0) + qmul(quat[3], p1));
    q3 = clamp32(qmul(quat[3], p0) - qmul(quat[2], p1));

    if (quat[1] < angle_limit)
      command = clamp32(-(qmul(angle_gain, qmul(q0, q1)) + qmul(rate_gain, rate)));
    else
      command = (rate > rate_threshold) ? -One : 0;
    quat[0] = q0;
    quat[1] = q1;
    quat[2] = q2;
    quat[3] = q3;
    return res;
  endfunction

  assign pending_ticks = expected_ticks.size();

  // Predict on input transfers, compare on output transfers.
  always @(posedge clk) begin
    tick_result_t want, got;
    if (!rst_n) begin
      restore_defaults();
      expected_ticks.delete();
      fail_count = 0;
      ticks_checked = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_RATE_PER_COUNT: rate_per_count = cfg_data[24:0];
          REG_TICK_PERIOD:    tick_period    = cfg_data[24:0];
          REG_ANGLE_GAIN:     angle_gain     = cfg_data[30:0];
          REG_RATE_GAIN:      rate_gain      = cfg_data[30:0];
          REG_RATE_THRESHOLD: rate_threshold = longint'($signed(cfg_data));
          REG_ANGLE_LIMIT:    angle_limit    = longint'($signed(cfg_data[25:0]));
          REG_PWM_STEP:       pwm_step       = cfg_data[24:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.pulses    = out_tdata[7:0];
        got.direction = out_tdata[8];
        got.rate      = out_tdata[40:9];
        if (expected_ticks.size() == 0) begin
          $error("unexpected result transfer: %h", out_tdata);
          fail_count++;
        end else begin
          want = expected_ticks.pop_front();
          ticks_checked++;
          if (got.pulses !== want.pulses) begin
            $error("pulse_count: expected %0d, actual %0d", want.pulses, got.pulses);
            fail_count++;
          end
          if (got.direction !== want.direction) begin
            $error("drive_direction: expected %0d, actual %0d",
                   want.direction, got.direction);
            fail_count++;
          end
          if (got.rate !== want.rate) begin
            $error("rate_estimate: expected %0d, actual %0d", want.rate, got.rate);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_ticks.push_back(advance_tick(in_tdata[10:0]));
    end
  end

endmodule

@@ tb/quaternion_attitude_rate_controller_tb.sv @@
// ----------------------------------------------------------------------------
// Attitude rate controller testbench
// Drives encoder ticks and register settings into the controller, stalls the
// result side at random and leaves prediction and checking to the checker.
// ----------------------------------------------------------------------------
module quaternion_attitude_rate_controller_tb;
  import qarc_pkg::*;

  localparam int WatchdogLimit  = 20000;
  localparam int LongHoldAfter  = 650;
  localparam int LongHoldCycles = 300;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [10:0] encoder_count
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // [7:0] pulse_count, [8] drive_direction, [40:9] rate_estimate
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  int fail_count, pending_ticks, ticks_checked;
  int idle_cycles;
  int sent;

  quaternion_attitude_rate_controller dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_wr_en, .cfg_index, .cfg_data
  );

  quaternion_attitude_rate_controller_checker checker_i (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_wr_en, .cfg_index, .cfg_data,
    .fail_count, .pending_ticks, .ticks_checked
  );

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  // Watchdog: cycles without any transfer.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog expired");
      $display("quaternion_attitude_rate_controller_tb: errors");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold after a fixed number of results.
  initial begin
    int gap;
    int taken;
    taken = 0;
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (taken == LongHoldAfter) begin
        out_tready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk);
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk iff out_tvalid);
      taken++;
    end
  end

  // Valid stays high across back-to-back ticks; a gap or a drain lowers it.
  task automatic send_tick(logic [10:0] count, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, count};
    @(posedge clk iff in_tready);
    sent++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Let the block finish its tick before touching registers.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk iff pending_ticks == 0);
    repeat (200) @(posedge clk);
  endtask

  // Pick a register setting, biased toward the ends of each range.
  function automatic logic [31:0] pick(logic [2:0] idx);
    int sel;
    sel = $urandom_range(0, 3);
    case (idx)
      REG_RATE_PER_COUNT, REG_TICK_PERIOD, REG_PWM_STEP:
        return (sel == 0) ? 32'd0 : (sel == 1) ? 32'h1000000 : $urandom_range(0, 32'h1000000);
      REG_ANGLE_GAIN, REG_RATE_GAIN:
        return (sel == 0) ? 32'd0 : (sel == 1) ? 32'h7FFFFFFF : $urandom_range(0, 32'h0C000000);
      REG_RATE_THRESHOLD:
        return (sel == 0) ? 32'h80000000 : (sel == 1) ? 32'h7FFFFFFF : $urandom();
      REG_ANGLE_LIMIT:
        return (sel == 0) ? 32'hFF000000 : (sel == 1) ? 32'h01000000
               : $urandom_range(0, 32'h2000000) - 32'h1000000;
      default: return 32'd0;
    endcase
  endfunction

  initial begin
    logic [10:0] pos;
    int phase, n;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sent = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: count extremes, wrap in both directions, half-range distances.
    send_tick(11'd0, 0);
    send_tick(11'd1, 0);
    send_tick(11'd2047, 0);
    send_tick(11'd0, 0);
    send_tick(11'd1024, 0);   // exactly half range counting up
    send_tick(11'd0, 0);      // exactly half range counting down
    send_tick(11'd1023, 0);
    send_tick(11'd0, 0);
    send_tick(11'd1025, 0);
    send_tick(11'h555, 0);
    send_tick(11'h2AA, 0);
    send_tick(11'h7FF, 0);
    drain();

    // Command equal to the step, zero step, saturating gains.
    write_reg(REG_PWM_STEP, 32'd0);
    write_reg(REG_ANGLE_GAIN, 32'h7FFFFFFF);
    write_reg(REG_RATE_GAIN, 32'h7FFFFFFF);
    write_reg(REG_RATE_PER_COUNT, 32'h1000000);
    write_reg(REG_TICK_PERIOD, 32'h1000000);
    write_reg(REG_ANGLE_LIMIT, 32'h01000000);
    write_reg(REG_RATE_THRESHOLD, 32'h80000000);
    for (int i = 0; i < 8; i++) send_tick(11'(i * 300), 0);
    drain();
    write_reg(REG_PWM_STEP, 32'h1000000);
    write_reg(REG_ANGLE_LIMIT, 32'hFF000000);
    write_reg(REG_RATE_THRESHOLD, 32'h7FFFFFFF);
    send_tick(11'd5, 0);
    send_tick(11'd5, 0);
    send_tick(11'd0, 0);
    drain();

    // Random phases; the first writes every register, later ones rewrite a random subset.
    pos = 0;
    for (phase = 0; phase < 16; phase++) begin
      if (phase == 3) rst_n <= 1'b1;  // no reset again; keep the driver stable
      for (int r = 0; r <= 6; r++)
        if (phase == 0 || $urandom_range(0, 1)) write_reg(3'(r), pick(3'(r)));
      // A mix of smooth motion, fast spin and random jumps.
      n = 100;
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 3))
          0: pos = pos + 11'($urandom_range(0, 6)) - 11'd3;
          1: pos = pos + 11'($urandom_range(0, 60));
          2: pos = pos - 11'($urandom_range(0, 60));
          default: pos = 11'($urandom_range(0, 2047));
        endcase
        send_tick(pos, (phase % 4 == 1));
      end
      drain();   // sender waits until every result has arrived
    end

    @(posedge clk iff pending_ticks == 0);
    repeat (200) @(posedge clk);
    $display("sent %0d encoder ticks over 16 random register settings, %0d results checked",
             sent, ticks_checked);
    if (fail_count == 0)
      $display("quaternion_attitude_rate_controller_tb: clean");
    else
      $display("quaternion_attitude_rate_controller_tb: errors");
    $finish;
  end

endmodule
